FILE: hdl/pilr_pkg.sv
// ----------------------------------------------------------------------------
// pilr_pkg
// Shared types and constants for the PCI INTx link IRQ router.
// ----------------------------------------------------------------------------
package pilr_pkg;

	localparam int DEVICE_W     = 5;
	localparam int PIN_W        = 2;
	localparam int PINS_PER_DEV = 4;
	localparam int LINKS        = 4;
	localparam int LINK_W       = 2;
	localparam int IRQ_W        = 4;
	localparam int COUNT_W      = 6;
	localparam int CFG_IDX_W    = 8;
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINK0_ROUTE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINK1_ROUTE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINK2_ROUTE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINK3_ROUTE = 8'd3;

	// One line level change event
	typedef struct packed {
		logic                level;
		logic [PIN_W-1:0]    pin;
		logic [DEVICE_W-1:0] device;
	} pilr_evt_t;

	// Write side of the line state RAM
	typedef struct packed {
		logic                    en;
		logic [DEVICE_W-1:0]     addr;
		logic [PINS_PER_DEV-1:0] data;
	} pilr_wr_t;

endpackage

FILE: hdl/pilr_ram.sv
// ----------------------------------------------------------------------------
// pilr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pilr_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/pci_intx_link_irq_router_core.sv
// ----------------------------------------------------------------------------
// pci_intx_link_irq_router_core
// Routes PCI INTx line level changes through four shared links to ISA IRQs.
// ----------------------------------------------------------------------------
// Output: a result transfer is offered from the output register that stage 1
//   loads, once its input transfer has passed through the stage 1 register.
// Throughput: one event per cycle unless output stalls; the line state RAM
//   read-modify-write (read at accept, modify, write back in stage 1) sets it.
// Reset: routes, link counters, row valid flags and pipeline valids clear at
//   once; the RAM itself is not swept, rows never written read as all clear.
// ----------------------------------------------------------------------------
module pci_intx_link_irq_router_core #(
	parameter int NUM_DEVICES = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Event stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [4:0] device, [6:5] pin, [7] level
	input  logic [pilr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// Result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [3:0] isa_irq, [4] irq_level, [7:5] zero
	output logic [pilr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// Configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pilr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pilr_pkg::IRQ_W-1:0]          cfg_data
);

	localparam int DEV_AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

	// ------------------------------------------------------------------
	// Configuration: four route registers, always ready
	// ------------------------------------------------------------------
	logic [pilr_pkg::IRQ_W-1:0] route_q [pilr_pkg::LINKS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pilr_pkg::LINKS; i++) begin
				route_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pilr_pkg::REG_LINK0_ROUTE: route_q[0] <= cfg_data;
				pilr_pkg::REG_LINK1_ROUTE: route_q[1] <= cfg_data;
				pilr_pkg::REG_LINK2_ROUTE: route_q[2] <= cfg_data;
				pilr_pkg::REG_LINK3_ROUTE: route_q[3] <= cfg_data;
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 0: accept a transfer and issue the row read
	// ------------------------------------------------------------------
	pilr_pkg::pilr_evt_t in_evt;
	logic                in_xfer;
	logic                adv;      // stage 1 moves on this edge
	logic                out_free;

	assign in_evt   = pilr_pkg::pilr_evt_t'(s_axis_tdata);
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign in_xfer  = s_axis_tvalid && s_axis_tready;

	// ------------------------------------------------------------------
	// Stage 1: row data back from RAM, modify, write back
	// ------------------------------------------------------------------
	logic                valid_s1;
	pilr_pkg::pilr_evt_t evt_s1;

	assign adv           = !valid_s1 || out_free;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			evt_s1 <= in_evt;
		end
	end

	logic [DEV_AW-1:0]                 rd_addr;
	logic [DEV_AW-1:0]                 addr_s1;
	logic [pilr_pkg::PINS_PER_DEV-1:0] ram_rdata;
	pilr_pkg::pilr_wr_t                wr;

	assign rd_addr = in_evt.device[DEV_AW-1:0];
	assign addr_s1 = evt_s1.device[DEV_AW-1:0];

	pilr_ram #(
		.WIDTH (pilr_pkg::PINS_PER_DEV),
		.DEPTH (NUM_DEVICES)
	) u_line_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr[DEV_AW-1:0]),
		.wdata (wr.data),
		.re    (in_xfer),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Rows read as all clear until first written
	logic [NUM_DEVICES-1:0] row_vld_q;

	// Last row written: a read issued on that same edge returns stale data
	logic                              fwd_vld_q;
	logic [DEV_AW-1:0]                 fwd_addr_q;
	logic [pilr_pkg::PINS_PER_DEV-1:0] fwd_row_q;

	// Per-link assert counters
	logic [pilr_pkg::COUNT_W-1:0] count_q [pilr_pkg::LINKS];

	logic                              fwd_hit;
	logic                              in_range;
	logic [pilr_pkg::PINS_PER_DEV-1:0] row_rd;
	logic [pilr_pkg::PINS_PER_DEV-1:0] row_new;
	logic                              change;
	logic [pilr_pkg::LINK_W-1:0]       link;
	logic [pilr_pkg::COUNT_W-1:0]      cnt;
	logic [pilr_pkg::COUNT_W-1:0]      cnt_new;
	logic [pilr_pkg::IRQ_W-1:0]        route;
	logic                              emit;
	logic                              commit;

	assign in_range = ({1'b0, evt_s1.device} < (pilr_pkg::DEVICE_W + 1)'(NUM_DEVICES));
	assign fwd_hit  = fwd_vld_q && (fwd_addr_q == addr_s1);

	always_comb begin
		if (fwd_hit) begin
			row_rd = fwd_row_q;
		end else if (row_vld_q[addr_s1]) begin
			row_rd = ram_rdata;
		end else begin
			row_rd = '0;
		end
		row_new             = row_rd;
		row_new[evt_s1.pin] = evt_s1.level;
	end

	assign change = in_range && (row_rd[evt_s1.pin] != evt_s1.level);

	// Link is (device + pin) mod 4: two-bit wraparound add
	assign link  = evt_s1.device[pilr_pkg::LINK_W-1:0] + evt_s1.pin;
	assign cnt   = count_q[link];
	assign route = route_q[link];

	always_comb begin
		if (evt_s1.level) begin
			cnt_new = cnt + pilr_pkg::COUNT_W'(1);
			emit    = change && (route != '0) && (cnt == '0);
		end else begin
			cnt_new = cnt - pilr_pkg::COUNT_W'(1);
			emit    = change && (route != '0) && (cnt == pilr_pkg::COUNT_W'(1));
		end
	end

	assign commit  = valid_s1 && adv && change;
	assign wr.en   = commit;
	assign wr.addr = pilr_pkg::DEVICE_W'(addr_s1);
	assign wr.data = row_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			fwd_vld_q <= 1'b0;
		end else begin
			if (commit) begin
				row_vld_q[addr_s1] <= 1'b1;
			end
			if (adv) begin
				fwd_vld_q <= commit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			fwd_addr_q <= addr_s1;
			fwd_row_q  <= row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pilr_pkg::LINKS; i++) begin
				count_q[i] <= '0;
			end
		end else if (commit) begin
			count_q[link] <= cnt_new;
		end
	end

	// ------------------------------------------------------------------
	// Output register: hold the result until the transfer completes
	// ------------------------------------------------------------------
	logic                       out_valid_q;
	logic [pilr_pkg::IRQ_W-1:0] out_irq_q;
	logic                       out_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv && emit) begin
			out_irq_q   <= route;
			out_level_q <= evt_s1.level;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(pilr_pkg::OUT_TDATA_W - pilr_pkg::IRQ_W - 1)'(0),
		out_level_q, out_irq_q};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_out_routed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_irq_q != '0))
		else $error("result offered with an unrouted IRQ");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> in_range)
		else $error("line RAM written for a device beyond range");

	a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> (fwd_vld_q && (fwd_addr_q == $past(addr_s1))))
		else $error("forwarding register missed a row write");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with stage 1 empty");

	a_assert_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && emit && evt_s1.level) |=> (count_q[$past(link)] == pilr_pkg::COUNT_W'(1)))
		else $error("assert edge emitted without counter leaving zero");

endmodule
